[rtl/pdt_pkg.sv]
// Shared constants and codes for the packet delivery tracker.
`timescale 1ns / 1ps
package pdt_pkg;
	localparam int HOSTS       = 4;
	localparam int INFL_DEPTH  = 16;
	localparam int ACK_DEPTH   = 16;

	localparam int HOST_IW = (HOSTS > 1) ? $clog2(HOSTS) : 1;
	localparam int IF_IW   = $clog2(INFL_DEPTH);
	localparam int IF_CW   = $clog2(INFL_DEPTH + 1);
	localparam int IF_AW   = (HOSTS * INFL_DEPTH > 1) ? $clog2(HOSTS * INFL_DEPTH) : 1;
	localparam int ACK_IW  = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
	localparam int ACK_CW  = $clog2(ACK_DEPTH + 1);
	localparam int ACK_AW  = (HOSTS * ACK_DEPTH > 1) ? $clog2(HOSTS * ACK_DEPTH) : 1;

	localparam logic [15:0] TIMEOUT_RST = 16'd2000;

	localparam logic [2:0] OP_RECV    = 3'd0;
	localparam logic [2:0] OP_SENT    = 3'd1;
	localparam logic [2:0] OP_ACK     = 3'd2;
	localparam logic [2:0] OP_TICK    = 3'd3;
	localparam logic [2:0] OP_DRAIN   = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	localparam logic [2:0] K_ACCEPTED  = 3'd0;
	localparam logic [2:0] K_DROPPED   = 3'd1;
	localparam logic [2:0] K_DELIVERED = 3'd2;
	localparam logic [2:0] K_LOST      = 3'd3;
	localparam logic [2:0] K_ACKOUT    = 3'd4;
	localparam logic [2:0] K_OVERFLOW  = 3'd5;
endpackage

[rtl/pdt_ifs.sv]
// Channel interfaces: input beats, result beats and the timeout register write.
`timescale 1ns / 1ps
interface pdt_pkt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [1:0]  host;
	logic [31:0] tag;
	logic        only_ack;
	logic [31:0] now_ms;
	modport source (output valid, op, host, tag, only_ack, now_ms, input ready);
	modport sink   (input valid, op, host, tag, only_ack, now_ms, output ready);
endinterface

interface pdt_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [1:0]  out_host;
	logic [31:0] out_tag;
	logic        last;
	modport source (output valid, kind, out_host, out_tag, last, input ready);
	modport sink   (input valid, kind, out_host, out_tag, last, output ready);
endinterface

interface pdt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/pdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pdt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/packet_delivery_tracker.sv]
// Top level of the packet delivery tracker: per-host sequencer over the queue RAMs.
`timescale 1ns / 1ps
// Takes one operation beat at a time and returns its events on evt, the final one
// flagged by last. Receive and register pass through the finish state; clear, register
// with only_ack and unused ops return straight to idle. Ack and timeout walk each
// in-flight entry examined through check, RAM read and compare (one shared read port),
// plus a check for each host whose FIFO is or runs empty. Drain walks each queued ack
// the same way, plus a closing check. Each walking op also has its accept and finish
// states. A stalled evt holds the sequencer once the held event and the output register are both full.
// No clearing pass: the RAMs are only read where the per-host counts show data.
module packet_delivery_tracker import pdt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pdt_pkt_if.sink      pkt,
	pdt_evt_if.source    evt,
	pdt_cfg_if.sink      cfg
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [15:0]        timeout_q;
	logic [31:0]        exp_tag_q [HOSTS];
	logic [ACK_CW-1:0]  ack_cnt_q [HOSTS];
	logic [IF_IW-1:0]   head_q    [HOSTS];
	logic [IF_CW-1:0]   cnt_q     [HOSTS];

	logic [2:0]         state_q;
	logic [2:0]         op_q;
	logic [HOST_IW-1:0] host_q;
	logic [31:0]        tag_q;
	logic [31:0]        now_q;
	logic [ACK_CW-1:0]  idx_q;

	logic               hold_v_q;
	logic [2:0]         hold_kind_q;
	logic [HOST_IW-1:0] hold_host_q;
	logic [31:0]        hold_tag_q;

	logic               out_v_q;
	logic [2:0]         out_kind_q;
	logic [1:0]         out_host_q;
	logic [31:0]        out_tag_q;
	logic               out_last_q;

	// RAM ports
	logic               if_we, if_re, ak_we, ak_re;
	logic [IF_AW-1:0]   if_waddr, if_raddr;
	logic [ACK_AW-1:0]  ak_waddr, ak_raddr;
	logic [63:0]        if_rdata;
	logic [31:0]        ak_rdata;

	logic               acc, host_ok, can_push, emit_ok;
	logic [HOST_IW-1:0] in_h;
	logic [IF_CW:0]     tail_sum;
	logic [IF_IW-1:0]   tail_idx;
	logic [IF_IW-1:0]   head_nxt;
	logic [32:0]        expire_at;
	logic               expired;
	logic               last_host;

	logic               emit_en;
	logic [2:0]         emit_kind;
	logic [31:0]        emit_tag;
	logic               fin_push;

	assign pkt.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign acc       = pkt.valid && pkt.ready;
	assign host_ok   = (32'(pkt.host) < HOSTS);
	assign in_h      = HOST_IW'(pkt.host);
	assign can_push  = !out_v_q || evt.ready;
	assign emit_ok   = !hold_v_q || can_push;
	assign last_host = (host_q == HOST_IW'(HOSTS - 1));

	assign tail_sum = (IF_CW + 1)'(head_q[in_h]) + (IF_CW + 1)'(cnt_q[in_h]);
	assign tail_idx = (tail_sum >= (IF_CW + 1)'(INFL_DEPTH)) ?
		IF_IW'(tail_sum - (IF_CW + 1)'(INFL_DEPTH)) : IF_IW'(tail_sum);
	assign head_nxt = (head_q[host_q] == IF_IW'(INFL_DEPTH - 1)) ?
		'0 : IF_IW'(head_q[host_q] + 1'b1);

	assign expire_at = {1'b0, if_rdata[63:32]} + {17'b0, timeout_q};
	assign expired   = expire_at < {1'b0, now_q};

	assign if_waddr = IF_AW'(32'(in_h) * INFL_DEPTH + 32'(tail_idx));
	assign if_raddr = IF_AW'(32'(host_q) * INFL_DEPTH + 32'(head_q[host_q]));
	assign ak_waddr = ACK_AW'(32'(in_h) * ACK_DEPTH + 32'(ack_cnt_q[in_h][ACK_IW-1:0]));
	assign ak_raddr = ACK_AW'(32'(host_q) * ACK_DEPTH + 32'(idx_q[ACK_IW-1:0]));

	assign if_we = acc && host_ok && (pkt.op == OP_SENT) && !pkt.only_ack &&
		(cnt_q[in_h] < IF_CW'(INFL_DEPTH));
	assign ak_we = acc && host_ok && (pkt.op == OP_RECV) && !pkt.only_ack &&
		(pkt.tag >= exp_tag_q[in_h]) && (ack_cnt_q[in_h] < ACK_CW'(ACK_DEPTH));
	assign if_re = (state_q == S_RD) && (op_q != OP_DRAIN);
	assign ak_re = (state_q == S_RD) && (op_q == OP_DRAIN);

	pdt_ram #(.WIDTH(64), .DEPTH(HOSTS * INFL_DEPTH)) u_inflight (
		.clk   (clk),
		.we    (if_we),
		.waddr (if_waddr),
		.wdata ({pkt.now_ms, pkt.tag}),
		.re    (if_re),
		.raddr (if_raddr),
		.rdata (if_rdata)
	);

	pdt_ram #(.WIDTH(32), .DEPTH(HOSTS * ACK_DEPTH)) u_acks (
		.clk   (clk),
		.we    (ak_we),
		.waddr (ak_waddr),
		.wdata (pkt.tag),
		.re    (ak_re),
		.raddr (ak_raddr),
		.rdata (ak_rdata)
	);

	// Event generation in the compare state; idle-state events go straight to the buffer.
	always_comb begin
		emit_en   = 1'b0;
		emit_kind = K_LOST;
		emit_tag  = if_rdata[31:0];
		if (state_q == S_EV && emit_ok) begin
			unique case (op_q)
				OP_ACK: begin
					if (if_rdata[31:0] < tag_q) begin
						emit_en = 1'b1;
					end else if (if_rdata[31:0] == tag_q) begin
						emit_en   = 1'b1;
						emit_kind = K_DELIVERED;
					end
				end
				OP_TICK: begin
					emit_en = expired;
				end
				OP_DRAIN: begin
					emit_en   = 1'b1;
					emit_kind = K_ACKOUT;
					emit_tag  = ak_rdata;
				end
				default: begin
					emit_en = 1'b0;
				end
			endcase
		end
	end

	assign fin_push = (state_q == S_FIN) && hold_v_q && can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			for (int h = 0; h < HOSTS; h++) begin
				exp_tag_q[h] <= '0;
				ack_cnt_q[h] <= '0;
				head_q[h]    <= '0;
				cnt_q[h]     <= '0;
			end
			state_q  <= S_IDLE;
			host_q   <= '0;
			idx_q    <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				timeout_q <= cfg.data;
			end

			// output register: a buffered event moves out when a newer one arrives or at finish
			if (out_v_q && evt.ready) begin
				out_v_q <= 1'b0;
			end
			if ((emit_en && hold_v_q) || fin_push) begin
				out_v_q <= 1'b1;
			end
			if (emit_en) begin
				hold_v_q <= 1'b1;
			end else if (fin_push) begin
				hold_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						host_q <= (pkt.op == OP_TICK) ? '0 : in_h;
						idx_q  <= '0;
					end
					if (acc && host_ok) begin
						unique case (pkt.op)
							OP_RECV: begin
								hold_v_q <= 1'b1;
								state_q  <= S_FIN;
								if (!pkt.only_ack && pkt.tag >= exp_tag_q[in_h]) begin
									exp_tag_q[in_h] <= pkt.tag + 32'd1;
									if (ak_we) begin
										ack_cnt_q[in_h] <= ack_cnt_q[in_h] + 1'b1;
									end
								end
							end
							OP_SENT: begin
								if (!pkt.only_ack) begin
									hold_v_q <= 1'b1;
									state_q  <= S_FIN;
									if (if_we) begin
										cnt_q[in_h] <= cnt_q[in_h] + 1'b1;
									end
								end
							end
							OP_ACK, OP_TICK, OP_DRAIN: begin
								state_q <= S_CHK;
							end
							OP_CLEAR: begin
								exp_tag_q[in_h] <= '0;
								ack_cnt_q[in_h] <= '0;
								head_q[in_h]    <= '0;
								cnt_q[in_h]     <= '0;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end else if (acc && pkt.op == OP_TICK) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					unique case (op_q)
						OP_DRAIN: begin
							if (idx_q < ack_cnt_q[host_q] && idx_q < ACK_CW'(ACK_DEPTH)) begin
								state_q <= S_RD;
							end else begin
								ack_cnt_q[host_q] <= '0;
								state_q           <= S_FIN;
							end
						end
						OP_TICK: begin
							if (cnt_q[host_q] != '0) begin
								state_q <= S_RD;
							end else if (last_host) begin
								state_q <= S_FIN;
							end else begin
								host_q <= host_q + 1'b1;
							end
						end
						default: begin
							state_q <= (cnt_q[host_q] != '0) ? S_RD : S_FIN;
						end
					endcase
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (emit_ok) begin
						unique case (op_q)
							OP_ACK: begin
								if (if_rdata[31:0] <= tag_q) begin
									head_q[host_q] <= head_nxt;
									cnt_q[host_q]  <= cnt_q[host_q] - 1'b1;
								end
								state_q <= (if_rdata[31:0] < tag_q) ? S_CHK : S_FIN;
							end
							OP_TICK: begin
								state_q <= S_CHK;
								if (expired) begin
									head_q[host_q] <= head_nxt;
									cnt_q[host_q]  <= cnt_q[host_q] - 1'b1;
								end else if (last_host) begin
									state_q <= S_FIN;
								end else begin
									host_q <= host_q + 1'b1;
								end
							end
							default: begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_CHK;
							end
						endcase
					end
				end
				S_FIN: begin
					if (!hold_v_q || can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= pkt.op;
			tag_q  <= pkt.tag;
			now_q  <= pkt.now_ms;
			hold_host_q <= in_h;
			hold_tag_q  <= pkt.tag;
			if (pkt.op == OP_RECV) begin
				if (pkt.only_ack) begin
					hold_kind_q <= K_ACCEPTED;
				end else if (pkt.tag < exp_tag_q[in_h]) begin
					hold_kind_q <= K_DROPPED;
				end else begin
					hold_kind_q <= ak_we ? K_ACCEPTED : K_OVERFLOW;
				end
			end else begin
				hold_kind_q <= if_we ? K_ACCEPTED : K_OVERFLOW;
			end
		end
		if (emit_en) begin
			hold_kind_q <= emit_kind;
			hold_host_q <= host_q;
			hold_tag_q  <= emit_tag;
		end
		if ((emit_en && hold_v_q) || fin_push) begin
			out_kind_q <= hold_kind_q;
			out_host_q <= 2'(hold_host_q);
			out_tag_q  <= hold_tag_q;
			out_last_q <= fin_push;
		end
	end

	assign evt.valid    = out_v_q;
	assign evt.kind     = out_kind_q;
	assign evt.out_host = out_host_q;
	assign evt.out_tag  = out_tag_q;
	assign evt.last     = out_last_q;

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !hold_v_q)
		else $error("event buffer busy while idle");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (!hold_v_q || can_push))
		else $error("event raised with no room");
	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV && $past(state_q) != S_EV) |-> $past(state_q) == S_RD)
		else $error("compare without RAM read");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[host_q] <= IF_CW'(INFL_DEPTH))
		else $error("in-flight count beyond depth");
endmodule
